>>> hw/rtl/itlc_pkg.sv
// Package for the integer literal token classifier.
// Holds counter widths, the word DFA state type, result layout and helper functions.
// No dependencies; imported by every module of the block.
package itlc_pkg;

    // Width of the internal line and word counters.
    localparam int COUNT_WIDTH = 32;
    // Width of every count field on the result stream.
    localparam int OUT_W       = 32;

    // Result tdata layout, lowest bit first.
    localparam int CLS_LSB   = 0;
    localparam int CLS_W     = 3;
    localparam int OK_LSB    = CLS_LSB + CLS_W;
    localparam int LINE_LSB  = OK_LSB + 1;
    localparam int TLINE_LSB = LINE_LSB + OUT_W;
    localparam int WORDS_LSB = TLINE_LSB + OUT_W;
    localparam int DEC_LSB   = WORDS_LSB + OUT_W;
    localparam int OCT_LSB   = DEC_LSB + OUT_W;
    localparam int HEX_LSB   = OCT_LSB + OUT_W;
    localparam int BIN_LSB   = HEX_LSB + OUT_W;
    localparam int FIELD_W   = BIN_LSB + OUT_W;
    localparam int DATA_W    = ((FIELD_W + 7) / 8) * 8;

    // Result queue depth and count width.
    localparam int Q_DEPTH = 3;
    localparam int Q_CNT_W = 2;

    // Input kinds carried in tuser.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    // Word DFA states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE    = 13'b0_0000_0000_0001,
        S_ZERO    = 13'b0_0000_0000_0010,
        S_OCT_OK  = 13'b0_0000_0000_0100,
        S_DEC_OK  = 13'b0_0000_0000_1000,
        S_HEX_PRE = 13'b0_0000_0001_0000,
        S_HEX_OK  = 13'b0_0000_0010_0000,
        S_BIN_PRE = 13'b0_0000_0100_0000,
        S_BIN_OK  = 13'b0_0000_1000_0000,
        S_NONLIT  = 13'b0_0001_0000_0000,
        S_DEC_BAD = 13'b0_0010_0000_0000,
        S_OCT_BAD = 13'b0_0100_0000_0000,
        S_HEX_BAD = 13'b0_1000_0000_0000,
        S_BIN_BAD = 13'b1_0000_0000_0000
    } t_dfa;

    // Token classes as reported on the result stream.
    typedef enum logic [CLS_W-1:0] {
        CLS_DEC    = 3'd0,
        CLS_OCT    = 3'd1,
        CLS_HEX    = 3'd2,
        CLS_BIN    = 3'd3,
        CLS_NONLIT = 3'd4
    } t_cls;

    // Classification of the word held in the current DFA state.
    typedef struct packed {
        logic open;
        t_cls cls;
        logic ok;
    } t_word_info;

    // One result transaction.
    typedef struct packed {
        logic              is_summary;
        logic              last;
        logic [DATA_W-1:0] data;
    } t_result;

    // Push strobes into the result queue; b is used only together with a.
    typedef struct packed {
        logic a;
        logic b;
    } t_push;

    // Saturating increment of a counter.
    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    // Clamp a counter to the 32-bit output range.
    function automatic logic [OUT_W-1:0] clamp32(input t_cnt v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
    endfunction

endpackage

>>> hw/rtl/itlc_dfa.sv
// Word DFA of the integer literal token classifier: next state and word classification.
// Purely combinational; depends on itlc_pkg.
module itlc_dfa (
    input  itlc_pkg::t_dfa       i_state,
    input  logic [7:0]           i_char,
    output itlc_pkg::t_dfa       o_next,
    output itlc_pkg::t_word_info o_word,
    output logic                 o_is_ws,
    output logic                 o_is_lf
);
    import itlc_pkg::*;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF_LO = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;

    logic is_dec;
    logic is_oct;
    logic is_bin;
    logic is_hex;

    // Character classes.
    assign is_dec  = (i_char >= CH_0) && (i_char <= CH_9);
    assign is_oct  = (i_char >= CH_0) && (i_char <= CH_7);
    assign is_bin  = (i_char == CH_0) || (i_char == CH_1);
    assign is_hex  = is_dec || ((i_char >= CH_LA) && (i_char <= CH_LF_LO))
                   || ((i_char >= CH_UA) && (i_char <= CH_UF));
    assign o_is_ws = (i_char == CH_SP) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign o_is_lf = (i_char == CH_NL);

    // Transition on one non-space byte.
    always_comb begin
        unique case (i_state)
            S_IDLE: begin
                if (i_char == CH_0) o_next = S_ZERO;
                else if (is_dec)    o_next = S_DEC_OK;
                else                o_next = S_NONLIT;
            end
            S_ZERO: begin
                if ((i_char == CH_LX) || (i_char == CH_UX))      o_next = S_HEX_PRE;
                else if ((i_char == CH_LB) || (i_char == CH_UB)) o_next = S_BIN_PRE;
                else if (is_oct)                                 o_next = S_OCT_OK;
                else                                             o_next = S_OCT_BAD;
            end
            S_OCT_OK:             o_next = is_oct ? S_OCT_OK : S_OCT_BAD;
            S_DEC_OK:             o_next = is_dec ? S_DEC_OK : S_DEC_BAD;
            S_HEX_PRE, S_HEX_OK:  o_next = is_hex ? S_HEX_OK : S_HEX_BAD;
            S_BIN_PRE, S_BIN_OK:  o_next = is_bin ? S_BIN_OK : S_BIN_BAD;
            S_DEC_BAD, S_OCT_BAD,
            S_HEX_BAD, S_BIN_BAD: o_next = i_state;
            default:              o_next = S_NONLIT;
        endcase
    end

    // Class and validity of the word that the current state would close.
    always_comb begin
        o_word.open = (i_state != S_IDLE);
        unique case (i_state)
            S_DEC_OK:             begin o_word.cls = CLS_DEC; o_word.ok = 1'b1; end
            S_DEC_BAD:            begin o_word.cls = CLS_DEC; o_word.ok = 1'b0; end
            S_OCT_OK:             begin o_word.cls = CLS_OCT; o_word.ok = 1'b1; end
            S_ZERO, S_OCT_BAD:    begin o_word.cls = CLS_OCT; o_word.ok = 1'b0; end
            S_HEX_OK:             begin o_word.cls = CLS_HEX; o_word.ok = 1'b1; end
            S_HEX_PRE, S_HEX_BAD: begin o_word.cls = CLS_HEX; o_word.ok = 1'b0; end
            S_BIN_OK:             begin o_word.cls = CLS_BIN; o_word.ok = 1'b1; end
            S_BIN_PRE, S_BIN_BAD: begin o_word.cls = CLS_BIN; o_word.ok = 1'b0; end
            default:              begin o_word.cls = CLS_NONLIT; o_word.ok = 1'b1; end
        endcase
    end

endmodule

>>> hw/rtl/itlc_rslt_q.sv
// Three-entry result queue of the integer literal token classifier.
// Takes up to two results per cycle and drains one; depends on itlc_pkg.
module itlc_rslt_q (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itlc_pkg::t_push               i_push,
    input  itlc_pkg::t_result             i_res_a,
    input  itlc_pkg::t_result             i_res_b,
    input  logic                          i_pop,
    output itlc_pkg::t_result             o_head,
    output logic [itlc_pkg::Q_CNT_W-1:0]  o_cnt
);
    import itlc_pkg::*;

    t_result              r_q [Q_DEPTH];
    t_result              n_q [Q_DEPTH];
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic [Q_CNT_W-1:0]   cnt_after_pop;

    assign cnt_after_pop = r_cnt - Q_CNT_W'(i_pop);

    // Shift on a pop, then place new results right behind the kept ones.
    always_comb begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            n_q[i] = i_pop ? r_q[(i + 1 < Q_DEPTH) ? i + 1 : i] : r_q[i];
            if (i_push.a && (Q_CNT_W'(i) == cnt_after_pop)) begin
                n_q[i] = i_res_a;
            end
            if (i_push.b && (Q_CNT_W'(i) == cnt_after_pop + Q_CNT_W'(1))) begin
                n_q[i] = i_res_b;
            end
        end
        n_cnt = cnt_after_pop + Q_CNT_W'(i_push.a) + Q_CNT_W'(i_push.b);
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head = r_q[0];
    assign o_cnt  = r_cnt;

endmodule

>>> hw/rtl/integer_literal_token_classifier.sv
// Integer literal token classifier: top level with word state, counters and stream ports.
// Depends on itlc_pkg, itlc_dfa and itlc_rslt_q.
// Results pass through the registered result queue before they reach the stream.
// Input: one byte per cycle while the queue holds fewer than two results; an end item that
// closes an open word yields two results, the word report and then the totals.
// Reset: synchronous, active low; clears word state, counters and the queue, input not ready.
module integer_literal_token_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] char_byte
    input  logic                          s_axis_tuser,  // [0] kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [2:0] token_class, [3] token_valid, [35:4] line_number, [67:36] total_lines,
    // [99:68] total_words, [131:100] decimal_count, [163:132] octal_count,
    // [195:164] hex_count, [227:196] binary_count, [231:228] zero
    output logic [itlc_pkg::DATA_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tuser,  // [0] is_summary
    output logic                          m_axis_tlast   // last_of_run
);
    import itlc_pkg::*;

    t_dfa               r_state,     n_state;
    logic               r_line_open, n_line_open;
    t_cnt               r_nl,        n_nl;
    t_cnt               r_words,     n_words;
    t_cnt               r_dec,       n_dec;
    t_cnt               r_oct,       n_oct;
    t_cnt               r_hex,       n_hex;
    t_cnt               r_bin,       n_bin;
    logic               r_alive;

    t_dfa               dfa_next;
    t_word_info         word;
    logic               is_ws;
    logic               is_lf;
    logic               accept;
    logic               pop;
    t_push              push;
    t_result            word_res;
    t_result            sum_res;
    t_result            res_a;
    t_result            head;
    logic [Q_CNT_W-1:0] q_cnt;

    itlc_dfa u_dfa (
        .i_state (r_state),
        .i_char  (s_axis_tdata),
        .o_next  (dfa_next),
        .o_word  (word),
        .o_is_ws (is_ws),
        .o_is_lf (is_lf)
    );

    // Input is taken while at least two queue entries are free after reset.
    assign s_axis_tready = r_alive && (q_cnt < Q_CNT_W'(2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Word state and counter updates, and the results of this transaction.
    always_comb begin
        n_state     = r_state;
        n_line_open = r_line_open;
        n_nl        = r_nl;
        n_words     = r_words;
        n_dec       = r_dec;
        n_oct       = r_oct;
        n_hex       = r_hex;
        n_bin       = r_bin;
        push        = '0;

        // Word report for the word held in the DFA.
        word_res                                 = '0;
        word_res.last                            = (s_axis_tuser == KIND_BYTE);
        word_res.data[CLS_LSB +: CLS_W]          = word.cls;
        word_res.data[OK_LSB]                    = word.ok;
        word_res.data[LINE_LSB +: OUT_W]         = clamp32(sat_inc(r_nl));

        // Closing a word counts it and, when valid, its class.
        if (accept && word.open && (is_ws || (s_axis_tuser == KIND_END))) begin
            n_state = S_IDLE;
            n_words = sat_inc(r_words);
            if (word.ok && (word.cls == CLS_DEC)) n_dec = sat_inc(r_dec);
            if (word.ok && (word.cls == CLS_OCT)) n_oct = sat_inc(r_oct);
            if (word.ok && (word.cls == CLS_HEX)) n_hex = sat_inc(r_hex);
            if (word.ok && (word.cls == CLS_BIN)) n_bin = sat_inc(r_bin);
        end

        // Totals, taken after the closing word has been counted.
        sum_res                            = '0;
        sum_res.is_summary                 = 1'b1;
        sum_res.last                       = 1'b1;
        sum_res.data[TLINE_LSB +: OUT_W]   = clamp32(r_line_open ? sat_inc(r_nl) : r_nl);
        sum_res.data[WORDS_LSB +: OUT_W]   = clamp32(n_words);
        sum_res.data[DEC_LSB +: OUT_W]     = clamp32(n_dec);
        sum_res.data[OCT_LSB +: OUT_W]     = clamp32(n_oct);
        sum_res.data[HEX_LSB +: OUT_W]     = clamp32(n_hex);
        sum_res.data[BIN_LSB +: OUT_W]     = clamp32(n_bin);

        res_a = word_res;

        if (accept) begin
            if (s_axis_tuser == KIND_BYTE) begin
                if (is_ws) begin
                    push.a      = word.open;
                    n_line_open = !is_lf;
                    if (is_lf) n_nl = sat_inc(r_nl);
                end else begin
                    n_state     = dfa_next;
                    n_line_open = 1'b1;
                end
            end else begin
                // End of input: optional word report, then totals, then clear.
                push.a      = 1'b1;
                push.b      = word.open;
                res_a       = word.open ? word_res : sum_res;
                n_state     = S_IDLE;
                n_line_open = 1'b0;
                n_nl        = '0;
                n_words     = '0;
                n_dec       = '0;
                n_oct       = '0;
                n_hex       = '0;
                n_bin       = '0;
            end
        end
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line_open <= 1'b0;
            r_nl        <= '0;
            r_words     <= '0;
            r_dec       <= '0;
            r_oct       <= '0;
            r_hex       <= '0;
            r_bin       <= '0;
            r_alive     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line_open <= n_line_open;
            r_nl        <= n_nl;
            r_words     <= n_words;
            r_dec       <= n_dec;
            r_oct       <= n_oct;
            r_hex       <= n_hex;
            r_bin       <= n_bin;
            r_alive     <= 1'b1;
        end
    end

    itlc_rslt_q u_rslt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res_a (res_a),
        .i_res_b (sum_res),
        .i_pop   (pop),
        .o_head  (head),
        .o_cnt   (q_cnt)
    );

    // Result stream from the queue head.
    assign m_axis_tvalid = (q_cnt != '0);
    assign m_axis_tdata  = head.data;
    assign m_axis_tuser  = head.is_summary;
    assign m_axis_tlast  = head.last;

`ifndef SYNTHESIS
    // A double push only happens with room for both results.
    a_double_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.b |-> (q_cnt <= Q_CNT_W'(1)))
        else $error("double push into a result queue without room");

    // The second push is always paired with a first one.
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.b |-> push.a)
        else $error("second result pushed without the first");

    // An end item leaves the word state, the line and word counters and the line-open flag cleared.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == KIND_END)) |=>
            ((r_state == S_IDLE) && (r_words == '0) && (r_nl == '0) && !r_line_open))
        else $error("state not cleared after end of input");

    // A totals result always closes its run.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("totals result not marked last");

    // An accepted whitespace byte that closes a word produces a result next cycle.
    a_word_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && word.open && is_ws && (s_axis_tuser == KIND_BYTE)) |=> m_axis_tvalid)
        else $error("closed word produced no result");
`endif

endmodule
